// File: rtl/core/d64r_pkg.sv
package d64r_pkg;

    localparam int DividendWidth = 64;
    localparam int DivisorWidth  = 32;
    localparam int CountWidth    = $clog2(DividendWidth);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic den_zero;
    } dp_stat_t;

endpackage

// File: rtl/core/d64r_ctrl.sv
module d64r_ctrl
    import d64r_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.last || stat.den_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RUN:
            begin
                cmd.step = !stat.den_zero;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/d64r_dpath.sv
module d64r_dpath
    import d64r_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [DividendWidth-1:0] dividend,
    input  logic [DivisorWidth-1:0]  divisor,
    output dp_stat_t                 stat,
    output logic [DividendWidth-1:0] quotient,
    output logic [DivisorWidth-1:0]  remainder,
    output logic                     div_by_zero
);

    // num_reg shifts dividend bits out at the top and quotient bits in at the bottom
    logic [DividendWidth-1:0] num_reg;
    logic [DivisorWidth-1:0]  den_reg;
    logic [DivisorWidth-1:0]  part_reg;
    logic [CountWidth-1:0]    cnt_reg;
    logic                     zero_reg;

    logic [DivisorWidth:0]    trial;
    logic [DivisorWidth:0]    diff;
    logic                     fits;

    assign trial = {part_reg, num_reg[DividendWidth-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DivisorWidth];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            zero_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cnt_reg  <= '0;
            zero_reg <= (divisor == '0);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            part_reg <= '0;
        end
        else if (cmd.step)
        begin
            num_reg  <= {num_reg[DividendWidth-2:0], fits};
            part_reg <= fits ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
        end
    end

    assign stat.last     = (cnt_reg == CountWidth'(DividendWidth - 1));
    assign stat.den_zero = zero_reg;

    assign quotient    = zero_reg ? '0 : num_reg;
    assign remainder   = zero_reg ? '0 : part_reg;
    assign div_by_zero = zero_reg;

endmodule

// File: rtl/core/div64_by_32_restoring.sv
// done rises in ST_DONE once the run of steps ends, or with no steps when divisor is zero
// one quotient bit per cycle from the radix-2 shift-and-subtract step, 64 steps
// a new item is taken only in idle, not while one is running; start taken the cycle after done
// results show for one cycle under done; the receiver cannot stall
// async active-low reset returns the controller to idle, payload registers not reset
module div64_by_32_restoring
    import d64r_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DividendWidth-1:0] dividend,
    input  logic [DivisorWidth-1:0]  divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DividendWidth-1:0] quotient,
    output logic [DivisorWidth-1:0]  remainder,
    output logic                     div_by_zero
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    d64r_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    d64r_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dividend    (dividend),
        .divisor     (divisor),
        .stat        (stat),
        .quotient    (quotient),
        .remainder   (remainder),
        .div_by_zero (div_by_zero)
    );

endmodule

// File: dv/div64_by_32_restoring_tb.sv
`timescale 1ns / 100ps

module div64_by_32_restoring_tb;
    import d64r_pkg::*;

    localparam int NumDirected = 16;
    localparam int NumRandom   = 1584;
    localparam logic [DividendWidth-1:0] AllOnes64 = '1;
    localparam logic [DivisorWidth-1:0]  AllOnes32 = '1;

    typedef struct packed {
        logic [DividendWidth-1:0] quo;
        logic [DivisorWidth-1:0]  rem;
        logic                     dbz;
    } div_result_t;

    typedef struct packed {
        logic                     typed;
        logic [DividendWidth-1:0] num;
        logic [DivisorWidth-1:0]  den;
        div_result_t              result;
    } div_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [DividendWidth-1:0] dividend;
    logic [DivisorWidth-1:0]  divisor;
    logic                     busy;
    logic                     done;
    logic [DividendWidth-1:0] quotient;
    logic [DivisorWidth-1:0]  remainder;
    logic                     div_by_zero;

    div_result_t pending_results[$];
    logic        item_typed;
    div_result_t item_result;
    int          error_count;
    int          idle_pct;

    // typed rows are plain arithmetic, the rest go through the predictor
    div_row_t directed_rows [NumDirected] = '{
        '{1'b1, 64'h0, 32'h1, '{64'h0, 32'h0, 1'b0}},
        '{1'b1, AllOnes64, 32'h1, '{AllOnes64, 32'h0, 1'b0}},
        '{1'b1, AllOnes64, AllOnes32, '{64'h0000_0001_0000_0001, 32'h0, 1'b0}},
        '{1'b1, 64'h0, 32'h0, '{64'h0, 32'h0, 1'b1}},
        '{1'b1, AllOnes64, 32'h0, '{64'h0, 32'h0, 1'b1}},
        '{1'b1, 64'h1234_5678_9abc_def0, 32'h0, '{64'h0, 32'h0, 1'b1}},
        '{1'b1, 64'h1, AllOnes32, '{64'h0, 32'h1, 1'b0}},
        '{1'b1, 64'h0000_0000_ffff_fffe, AllOnes32, '{64'h0, 32'hffff_fffe, 1'b0}},
        '{1'b1, 64'd100, 32'd7, '{64'd14, 32'd2, 1'b0}},
        '{1'b1, 64'h8000_0000_0000_0000, 32'h2, '{64'h4000_0000_0000_0000, 32'h0, 1'b0}},
        '{1'b1, 64'h8000_0000_0000_0000, 32'h8000_0000,
          '{64'h0000_0001_0000_0000, 32'h0, 1'b0}},
        '{1'b1, AllOnes64, 32'h8000_0000, '{64'h0000_0001_ffff_ffff, 32'h7fff_ffff, 1'b0}},
        '{1'b1, AllOnes64, 32'h2, '{64'h7fff_ffff_ffff_ffff, 32'h1, 1'b0}},
        '{1'b0, 64'h1234_5678_9abc_def0, 32'h9abc_def1, '{64'h0, 32'h0, 1'b0}},
        '{1'b0, 64'hfedc_ba98_7654_3210, 32'h3, '{64'h0, 32'h0, 1'b0}},
        '{1'b0, 64'h5555_aaaa_5555_aaaa, 32'haaaa_5555, '{64'h0, 32'h0, 1'b0}}
    };

    div64_by_32_restoring dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .dividend    (dividend),
        .divisor     (divisor),
        .busy        (busy),
        .done        (done),
        .quotient    (quotient),
        .remainder   (remainder),
        .div_by_zero (div_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // shift-and-subtract, one quotient bit per step, msb first
    function automatic div_result_t divide_u64_by_u32(logic [DividendWidth-1:0] num,
                                                      logic [DivisorWidth-1:0] den);
        div_result_t           r;
        logic [DivisorWidth:0] part;
        r    = '0;
        part = '0;
        if (den == '0)
        begin
            r.dbz = 1'b1;
            return r;
        end
        for (int b = DividendWidth - 1; b >= 0; b--)
        begin
            part  = {part[DivisorWidth-1:0], num[b]};
            r.quo = {r.quo[DividendWidth-2:0], 1'b0};
            if (part >= {1'b0, den})
            begin
                part     = part - {1'b0, den};
                r.quo[0] = 1'b1;
            end
        end
        r.rem = part[DivisorWidth-1:0];
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        div_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_error($sformatf("result with no item pending: q=%h r=%h z=%b",
                                           quotient, remainder, div_by_zero));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (quotient !== want.quo)
                        report_error($sformatf("quotient %h, want %h", quotient, want.quo));
                    if (remainder !== want.rem)
                        report_error($sformatf("remainder %h, want %h", remainder, want.rem));
                    if (div_by_zero !== want.dbz)
                        report_error($sformatf("div_by_zero %b, want %b",
                                               div_by_zero, want.dbz));
                end
            end
            if (start && !busy)
                pending_results.push_back(item_typed ? item_result
                                                     : divide_u64_by_u32(dividend, divisor));
        end
    end

    task automatic drive_item(logic [DividendWidth-1:0] num, logic [DivisorWidth-1:0] den,
                              logic typed, div_result_t result);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 80);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_typed  = typed;
        item_result = result;
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    task automatic drive_random_item();
        logic [DividendWidth-1:0] num;
        logic [DivisorWidth-1:0]  den;
        case ($urandom_range(0, 9))
            0: den = '0;
            1: den = $urandom_range(1, 15);
            2: den = 32'h1 << $urandom_range(0, 31);
            3: den = AllOnes32;
            4: den = AllOnes32 - $urandom_range(0, 15);
            default: den = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: num = $urandom_range(0, 255);
            1: num = AllOnes64;
            2: num = {32'h0, $urandom};
            3: num = {$urandom, 32'h0};
            4: num = {32'h0, den} * $urandom_range(0, 7) + $urandom_range(0, 3);
            default: num = {$urandom, $urandom};
        endcase
        drive_item(num, den, 1'b0, '0);
    endtask

    initial
    begin
        error_count = 0;
        idle_pct    = 27;
        item_typed  = 1'b0;
        item_result = '0;
        rst_n    = 1'b0;
        start    = 1'b0;
        dividend = '0;
        divisor  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_item(directed_rows[i].num, directed_rows[i].den,
                       directed_rows[i].typed, directed_rows[i].result);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 27 : (phase == 1) ? 60 : 0;
            for (int n = 0; n < NumRandom / 3; n++)
                drive_random_item();
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/d64r_pkg.sv
rtl/core/d64r_ctrl.sv
rtl/core/d64r_dpath.sv
rtl/core/div64_by_32_restoring.sv
dv/div64_by_32_restoring_tb.sv
